/* rtl/dnsm_pkg.sv */
package dnsm_pkg;

    localparam int DEPTH_W   = 16;
    localparam int THR_W     = 16;
    localparam int DIM_W     = 11;
    localparam int MASK_W    = 8;
    localparam int CNT_W     = 4;
    localparam int NB_COUNT  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd100;
    localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd480;
    localparam logic [DIM_W-1:0] DIM_MIN       = 11'd2;

    // neighbour bit positions in the masks
    localparam int NB_TL = 0;
    localparam int NB_TM = 1;
    localparam int NB_TR = 2;
    localparam int NB_MR = 3;
    localparam int NB_BR = 4;
    localparam int NB_BM = 5;
    localparam int NB_BL = 6;
    localparam int NB_ML = 7;

    typedef logic signed [DEPTH_W-1:0] t_depth;

    typedef struct packed {
        logic   op;
        t_depth depth_value;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] close_mask;
        logic [MASK_W-1:0] valid_mask;
        logic [CNT_W-1:0]  close_count;
        logic              frame_last;
    } t_out_word;

    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
    } t_edge_flags;

endpackage

/* rtl/dnsm_line_buf.sv */
module dnsm_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  dnsm_pkg::t_depth             i_wr_v,
    output dnsm_pkg::t_depth             o_up,
    output dnsm_pkg::t_depth             o_mid
);
    import dnsm_pkg::*;

    t_depth mem_upper  [MAX_WIDTH];
    t_depth mem_middle [MAX_WIDTH];
    t_depth r_up;
    t_depth r_mid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_upper[i_wr_addr]  <= r_mid;
            mem_middle[i_wr_addr] <= i_wr_v;
        end
    end

    // forward the word being written when the same column is read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_up  <= r_mid;
                r_mid <= i_wr_v;
            end else begin
                r_up  <= mem_upper[i_rd_addr];
                r_mid <= mem_middle[i_rd_addr];
            end
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

/* rtl/dnsm_mask.sv */
module dnsm_mask (
    input  dnsm_pkg::t_depth                     i_centre,
    input  dnsm_pkg::t_depth                     i_nbr [dnsm_pkg::NB_COUNT],
    input  dnsm_pkg::t_edge_flags                i_edges,
    input  logic [dnsm_pkg::THR_W-1:0]           i_threshold,
    output logic [dnsm_pkg::MASK_W-1:0]          o_close_mask,
    output logic [dnsm_pkg::MASK_W-1:0]          o_valid_mask,
    output logic [dnsm_pkg::CNT_W-1:0]           o_close_count
);
    import dnsm_pkg::*;

    logic [NB_COUNT-1:0]       in_frame;
    logic signed [DEPTH_W:0]   diff [NB_COUNT];
    logic signed [DEPTH_W:0]   mag  [NB_COUNT];
    logic [NB_COUNT-1:0]       valid;
    logic [NB_COUNT-1:0]       close;
    logic [CNT_W-1:0]          count;
    logic                      centre_ok;

    always_comb begin
        in_frame[NB_TL] = i_edges.top && i_edges.lft;
        in_frame[NB_TM] = i_edges.top;
        in_frame[NB_TR] = i_edges.top && i_edges.rgt;
        in_frame[NB_MR] = i_edges.rgt;
        in_frame[NB_BR] = i_edges.bot && i_edges.rgt;
        in_frame[NB_BM] = i_edges.bot;
        in_frame[NB_BL] = i_edges.bot && i_edges.lft;
        in_frame[NB_ML] = i_edges.lft;
    end

    assign centre_ok = (i_centre > 0);

    always_comb begin
        count = '0;
        for (int k = 0; k < NB_COUNT; k++) begin
            diff[k]  = $signed({i_nbr[k][DEPTH_W-1], i_nbr[k]})
                     - $signed({i_centre[DEPTH_W-1], i_centre});
            mag[k]   = diff[k][DEPTH_W] ? -diff[k] : diff[k];
            valid[k] = centre_ok && in_frame[k] && (i_nbr[k] > 0);
            close[k] = valid[k] && (DEPTH_W'(mag[k]) < i_threshold);
            count    = count + CNT_W'(close[k]);
        end
    end

    assign o_close_mask  = close;
    assign o_valid_mask  = valid;
    assign o_close_count = count;

endmodule

/* rtl/depth_neighbour_similarity_map_core.sv */
// channel | direction | handshake                 | word
// --------+-----------+---------------------------+-------------------------------
// in      | input     | i_in_valid / o_in_ready   | i_in_word  (op, depth_value)
// out     | output    | o_out_valid / i_out_ready | o_out_word (masks, count, last)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per cycle sustained unless the output stalls; the line store is read as a
// word enters stage one; the stage-one window masks are registered with o_out_valid.
// The result for a pixel arrives with the word frame_width+1 positions later.
// Reset (synchronous, active low) restores the config registers, the position, the window
// and the valid flags. A full output register that is not read stalls the mask stage only when it has a result.
module depth_neighbour_similarity_map_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dnsm_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dnsm_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dnsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dnsm_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import dnsm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    logic [THR_W-1:0] r_threshold;
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    t_depth           r_s1_v;

    t_depth           r_w01, r_w02, r_w11, r_w12, r_w21, r_w22;

    logic             r_out_valid;
    t_out_word        r_out_word, n_out_word;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic             in_fire, cfg_fire, s1_fire;
    logic             restart;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    t_depth           v0;
    t_depth           up, mid;
    t_depth           nbr [NB_COUNT];
    logic             col0, s1_prod, s1_last;
    t_edge_flags      edges;
    logic [MASK_W-1:0] close_mask, valid_mask;
    logic [CNT_W-1:0] close_count;

    always_comb begin
        if (r_frame_width < DIM_MIN) begin
            w_eff = DIM_MIN;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < DIM_MIN) begin
            h_eff = DIM_MIN;
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        restart = (32'(r_col) >= 32'(w_eff)) || (32'(r_row) > 32'(h_eff) + 1);
        c0      = restart ? '0 : r_col;
        r0      = restart ? '0 : r_row;
        v0      = (i_in_word.op || (32'(r0) >= 32'(h_eff))) ? '0 : i_in_word.depth_value;
        if (32'(r0) == 32'(h_eff) + 1) begin
            n_col = '0;
            n_row = '0;
        end else if (32'(c0) + 1 == 32'(w_eff)) begin
            n_col = '0;
            n_row = r0 + 1'b1;
        end else begin
            n_col = c0 + 1'b1;
            n_row = r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[THR_W-1:0];
                end
                REG_WIDTH: begin
                    r_frame_width <= i_cfg_data[DIM_W-1:0];
                    r_col         <= '0;
                    r_row         <= '0;
                end
                REG_HEIGHT: begin
                    r_frame_height <= i_cfg_data[DIM_W-1:0];
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_col <= c0;
            r_s1_row <= r0;
            r_s1_v   <= v0;
        end
    end

    dnsm_line_buf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rd_en  (in_fire),
        .i_rd_addr(c0),
        .i_wr_en  (s1_fire),
        .i_wr_addr(r_s1_col),
        .i_wr_v   (r_s1_v),
        .o_up     (up),
        .o_mid    (mid)
    );

    always_comb begin
        col0    = (r_s1_col == '0);
        s1_prod = col0 ? ((32'(r_s1_row) >= 2) && (32'(r_s1_row) <= 32'(h_eff) + 1))
                       : ((32'(r_s1_row) >= 1) && (32'(r_s1_row) <= 32'(h_eff)));
        s1_last = col0 && (32'(r_s1_row) == 32'(h_eff) + 1);
        edges.top = col0 ? (32'(r_s1_row) >= 3) : (32'(r_s1_row) >= 2);
        edges.bot = col0 ? (32'(r_s1_row) < 32'(h_eff) + 1) : (32'(r_s1_row) < 32'(h_eff));
        edges.lft = col0 ? 1'b1 : (32'(r_s1_col) >= 2);
        edges.rgt = !col0;
    end

    always_comb begin
        nbr[NB_TL] = r_w01;
        nbr[NB_TM] = r_w02;
        nbr[NB_TR] = up;
        nbr[NB_MR] = mid;
        nbr[NB_BR] = r_s1_v;
        nbr[NB_BM] = r_w22;
        nbr[NB_BL] = r_w21;
        nbr[NB_ML] = r_w11;
    end

    dnsm_mask u_mask (
        .i_centre     (r_w12),
        .i_nbr        (nbr),
        .i_edges      (edges),
        .i_threshold  (r_threshold),
        .o_close_mask (close_mask),
        .o_valid_mask (valid_mask),
        .o_close_count(close_count)
    );

    assign s1_fire = r_s1_valid && (!s1_prod || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w01 <= '0;
            r_w02 <= '0;
            r_w11 <= '0;
            r_w12 <= '0;
            r_w21 <= '0;
            r_w22 <= '0;
        end else if (s1_fire) begin
            r_w01 <= r_w02;
            r_w02 <= up;
            r_w11 <= r_w12;
            r_w12 <= mid;
            r_w21 <= r_w22;
            r_w22 <= r_s1_v;
        end
    end

    always_comb begin
        n_out_word.close_mask  = close_mask;
        n_out_word.valid_mask  = valid_mask;
        n_out_word.close_count = close_count;
        n_out_word.frame_last  = s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_prod) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_prod) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
